FILE: sv/per_antenna_time_interpolator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the per-antenna time interpolator
// Concurrent checks sampled on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PER_ANTENNA_TIME_INTERPOLATOR_ASSERT_SVH
`define PER_ANTENNA_TIME_INTERPOLATOR_ASSERT_SVH

// same-cycle implication
`define PATI_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pati same-cycle check failed");

// next-cycle implication
`define PATI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pati next-cycle check failed");

`endif

FILE: sv/pati_pkg.sv
// ----------------------------------------------------------------------------
// pati_pkg
// Sizes, codes, state type and controller/datapath bundles of the
// per-antenna time interpolator.
// ----------------------------------------------------------------------------
package pati_pkg;

	localparam int ROWS     = 1024;
	localparam int ANTENNAS = 64;
	localparam int NVAL     = 7;
	localparam int VAL_W    = 24;
	localparam int TIME_W   = 32;
	localparam int ANT_W    = 8;
	localparam int SUB_W    = 8;

	localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CNT_W  = ROW_AW + 1;
	localparam int ANT_AW = (ANTENNAS > 1) ? $clog2(ANTENNAS) : 1;
	localparam int PTR_W  = 2 * ROW_AW;
	localparam int VALS_W = NVAL * VAL_W;
	localparam int ROW_W  = TIME_W + ANT_W + SUB_W + VALS_W;
	localparam int K_W    = $clog2(NVAL);

	// arithmetic widths
	localparam int W_W    = TIME_W + 2;   // weights
	localparam int DEN_W  = TIME_W + 1;   // span magnitude
	localparam int PROD_W = W_W + VAL_W;
	localparam int ACC_W  = PROD_W + 1;
	localparam int Q_W    = VAL_W;        // quotient never exceeds 2^23
	localparam int QC_W   = $clog2(Q_W);

	localparam logic [VAL_W-1:0] BLANK   = 24'h800000;
	localparam logic [VAL_W-1:0] VAL_MAX = 24'h7FFFFF;

	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_CLEAR  = 2'd1,
		ACT_QUERY  = 2'd2
	} action_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_EXEC, ST_Q_IDX, ST_SCAN, ST_SCAN_CHK, ST_SCAN_INIT_F,
		ST_ADV_CHK, ST_ADV_EVAL, ST_RD_P, ST_LD_P, ST_RD_F, ST_LD_F,
		ST_WGT, ST_MUL_A, ST_MUL_B, ST_DIVS, ST_DIV, ST_STORE, ST_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic append;
		logic clear;
		logic q_start;
		logic q_load;
		logic scan_zero;
		logic scan_from_prior;
		logic scan_next;
		logic found_prior;
		logic fail_prior;
		logic found_follow;
		logic fail_follow;
		logic adv_rd;
		logic adv_take;
		logic rd_prior;
		logic ld_prior;
		logic rd_follow;
		logic ld_follow;
		logic wgt;
		logic mul_a;
		logic mul_b;
		logic div_start;
		logic store;
		logic res_blank;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       ant_bad;
		logic       started;
		logic       scan_end;
		logic       row_match;
		logic       adv_ok;
		logic       t_after;
		logic       div_done;
		logic       last_val;
		logic       out_free;
	} sts_t;

endpackage

FILE: sv/pati_ram.sv
// ----------------------------------------------------------------------------
// pati_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pati_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/pati_div.sv
// ----------------------------------------------------------------------------
// pati_div
// Restoring divider, one quotient bit per cycle, Q_W bits of quotient.
// The caller guarantees the quotient fits in Q_W bits.
// ----------------------------------------------------------------------------
module pati_div import pati_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [ACC_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [Q_W-1:0]   quot
);

	logic [ACC_W-1:0] rem_q;
	logic [ACC_W-1:0] dsh_q;
	logic [Q_W-1:0]   quot_q;
	logic [QC_W-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             fits;

	assign fits = rem_q >= dsh_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= QC_W'(Q_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// one trial subtraction per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			dsh_q  <= ACC_W'(den) << (Q_W - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			quot_q <= {quot_q[Q_W-2:0], fits};
			dsh_q  <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

FILE: sv/pati_ctrl.sv
// ----------------------------------------------------------------------------
// pati_ctrl
// Sequencer: decodes the captured item, walks the row store for the
// pointer search, then steps the seven weighted sums through the datapath.
// ----------------------------------------------------------------------------
module pati_ctrl import pati_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   find_prior_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (sts.action)
					ACT_QUERY: state_d = sts.ant_bad ? ST_OUT : ST_Q_IDX;
					default:   state_d = ST_IDLE;
				endcase
			end
			ST_Q_IDX:       state_d = sts.started ? ST_ADV_CHK : ST_SCAN;
			ST_SCAN:        state_d = sts.scan_end ? ST_ADV_CHK : ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if (!sts.row_match) state_d = ST_SCAN;
				else if (find_prior_q) state_d = ST_SCAN_INIT_F;
				else state_d = ST_ADV_CHK;
			end
			ST_SCAN_INIT_F: state_d = ST_SCAN;
			ST_ADV_CHK:     state_d = sts.adv_ok ? ST_ADV_EVAL : ST_RD_P;
			ST_ADV_EVAL:    state_d = sts.t_after ? ST_SCAN_INIT_F : ST_RD_P;
			ST_RD_P:        state_d = ST_LD_P;
			ST_LD_P:        state_d = ST_RD_F;
			ST_RD_F:        state_d = ST_LD_F;
			ST_LD_F:        state_d = ST_WGT;
			ST_WGT:         state_d = ST_MUL_A;
			ST_MUL_A:       state_d = ST_MUL_B;
			ST_MUL_B:       state_d = ST_DIVS;
			ST_DIVS:        state_d = ST_DIV;
			ST_DIV: begin
				if (sts.div_done) state_d = ST_STORE;
			end
			ST_STORE:       state_d = sts.last_val ? ST_OUT : ST_MUL_A;
			ST_OUT: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default:        state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EXEC: begin
				case (sts.action)
					ACT_APPEND: cmd.append = 1'b1;
					ACT_CLEAR:  cmd.clear  = 1'b1;
					ACT_QUERY: begin
						cmd.res_blank = sts.ant_bad;
						cmd.q_start   = !sts.ant_bad;
					end
					default: ;
				endcase
			end
			ST_Q_IDX: begin
				cmd.q_load    = 1'b1;
				cmd.scan_zero = !sts.started;
			end
			ST_SCAN: begin
				cmd.fail_prior  = sts.scan_end && find_prior_q;
				cmd.fail_follow = sts.scan_end && !find_prior_q;
			end
			ST_SCAN_CHK: begin
				cmd.scan_next    = !sts.row_match;
				cmd.found_prior  = sts.row_match && find_prior_q;
				cmd.found_follow = sts.row_match && !find_prior_q;
			end
			ST_SCAN_INIT_F: cmd.scan_from_prior = 1'b1;
			ST_ADV_CHK:     cmd.adv_rd = sts.adv_ok;
			ST_ADV_EVAL:    cmd.adv_take = sts.t_after;
			ST_RD_P:        cmd.rd_prior = 1'b1;
			ST_LD_P:        cmd.ld_prior = 1'b1;
			ST_RD_F:        cmd.rd_follow = 1'b1;
			ST_LD_F:        cmd.ld_follow = 1'b1;
			ST_WGT:         cmd.wgt = 1'b1;
			ST_MUL_A:       cmd.mul_a = 1'b1;
			ST_MUL_B:       cmd.mul_b = 1'b1;
			ST_DIVS:        cmd.div_start = 1'b1;
			ST_DIV:         ;
			ST_STORE:       cmd.store = 1'b1;
			ST_OUT:         cmd.out_load = sts.out_free;
			default:        ;
		endcase
	end

	// state register and search mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			find_prior_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_Q_IDX) begin
				find_prior_q <= 1'b1;
			end else if (state_q == ST_SCAN_INIT_F) begin
				find_prior_q <= 1'b0;
			end
		end
	end

endmodule

FILE: sv/pati_dp.sv
// ----------------------------------------------------------------------------
// pati_dp
// Datapath: row store, per-antenna pointer store and flags, search
// pointers, weight logic, shared multiplier, divider and output register.
// ----------------------------------------------------------------------------
module pati_dp import pati_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmd_t                          cmd,
	output sts_t                          sts,
	input  logic [ROW_W-1:0]              in_data,
	input  logic [1:0]                    in_action,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [VALS_W-1:0]             out_data
);

	// captured item
	logic [ROW_W-1:0]         in_q;
	logic [1:0]               act_q;
	logic signed [TIME_W-1:0] t_q;
	logic [ANT_W-1:0]         ant_q;
	logic [SUB_W-1:0]         sub_q;
	logic [ANT_AW-1:0]        idx;

	// persistent state
	logic [CNT_W-1:0]    row_count_q;
	logic [SUB_W-1:0]    cur_sub_q;
	logic [ANTENNAS-1:0] started_q;
	logic [ANTENNAS-1:0] pvld_q;
	logic [ANTENNAS-1:0] fvld_q;

	// working registers
	logic [ROW_AW-1:0] prior_q;
	logic [ROW_AW-1:0] follow_q;
	logic              pv_q;
	logic              fv_q;
	logic [CNT_W-1:0]  scan_q;

	logic signed [TIME_W-1:0] pt_q;
	logic signed [TIME_W-1:0] ft_q;
	logic [VALS_W-1:0]        p_vals_q;
	logic [VALS_W-1:0]        f_vals_q;

	logic signed [W_W-1:0]   wa_q, wb_q;
	logic [DEN_W-1:0]        d_q;
	logic [K_W-1:0]          k_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                    blank_q;
	logic                    neg_q;
	logic [VALS_W-1:0]       res_q;
	logic [VALS_W-1:0]       out_data_q;
	logic                    out_valid_q;

	// memories
	logic              row_we;
	logic [ROW_AW-1:0] row_raddr;
	logic [ROW_W-1:0]  row_rd;
	logic [PTR_W-1:0]  ptr_rd;

	logic signed [TIME_W-1:0] r_time;
	logic [ANT_W-1:0]         r_ant;
	logic [SUB_W-1:0]         r_sub;
	logic [VALS_W-1:0]        r_vals;

	// weight logic
	logic signed [W_W-1:0] t_x, pt_x, ft_x, span;
	logic signed [W_W-1:0] wa_d, wb_d;
	logic [DEN_W-1:0]      d_d;

	// per-value arithmetic
	logic signed [VAL_W-1:0]  p_val, f_val, m_val;
	logic signed [W_W-1:0]    aa, bb, m_w;
	logic signed [PROD_W-1:0] prod;
	logic [ACC_W-1:0]         mag, div_num;
	logic                     div_done;
	logic [Q_W-1:0]           quot;
	logic [VAL_W-1:0]         q_sat, res_val;

	assign t_q   = in_q[TIME_W-1:0];
	assign ant_q = in_q[TIME_W +: ANT_W];
	assign sub_q = in_q[TIME_W+ANT_W +: SUB_W];
	assign idx   = ANT_AW'(ant_q - 8'd1);

	assign r_time = row_rd[TIME_W-1:0];
	assign r_ant  = row_rd[TIME_W +: ANT_W];
	assign r_sub  = row_rd[TIME_W+ANT_W +: SUB_W];
	assign r_vals = row_rd[ROW_W-1 -: VALS_W];

	// row store: rows laid out as the input stream word
	assign row_we = cmd.append && (row_count_q < CNT_W'(ROWS));

	always_comb begin
		if (cmd.rd_prior) row_raddr = prior_q;
		else if (cmd.adv_rd || cmd.rd_follow) row_raddr = follow_q;
		else row_raddr = scan_q[ROW_AW-1:0];
	end

	pati_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_rows (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_count_q[ROW_AW-1:0]),
		.wdata (in_q),
		.raddr (row_raddr),
		.rdata (row_rd)
	);

	// pointer store: {follow, prior} per antenna
	pati_ram #(.WIDTH(PTR_W), .DEPTH(ANTENNAS)) u_ptrs (
		.clk   (clk),
		.we    (cmd.wgt),
		.waddr (idx),
		.wdata ({follow_q, prior_q}),
		.raddr (idx),
		.rdata (ptr_rd)
	);

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q  <= in_data;
			act_q <= in_action;
		end
	end

	// store fill, subarray and per-antenna flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= '0;
			cur_sub_q   <= '0;
			started_q   <= '0;
			pvld_q      <= '0;
			fvld_q      <= '0;
		end else begin
			if (row_we) begin
				row_count_q <= row_count_q + 1'b1;
			end
			if (cmd.clear) begin
				row_count_q <= '0;
				started_q   <= '0;
				pvld_q      <= '0;
				fvld_q      <= '0;
			end
			if (cmd.q_start && (sub_q != cur_sub_q)) begin
				cur_sub_q <= sub_q;
				started_q <= '0;
				pvld_q    <= '0;
				fvld_q    <= '0;
			end
			if (cmd.q_load) begin
				started_q[idx] <= 1'b1;
			end
			if (cmd.wgt) begin
				pvld_q[idx] <= pv_q;
				fvld_q[idx] <= fv_q;
			end
		end
	end

	// search pointers
	always_ff @(posedge clk) begin
		if (cmd.q_load) begin
			prior_q  <= ptr_rd[ROW_AW-1:0];
			follow_q <= ptr_rd[PTR_W-1:ROW_AW];
			pv_q     <= pvld_q[idx];
			fv_q     <= fvld_q[idx];
		end
		if (cmd.scan_zero) scan_q <= '0;
		if (cmd.scan_from_prior) scan_q <= CNT_W'(prior_q) + 1'b1;
		if (cmd.scan_next) scan_q <= scan_q + 1'b1;
		if (cmd.found_prior) begin
			prior_q <= scan_q[ROW_AW-1:0];
			pv_q    <= 1'b1;
		end
		if (cmd.fail_prior) begin
			pv_q <= 1'b0;
			fv_q <= 1'b0;
		end
		if (cmd.found_follow) begin
			follow_q <= scan_q[ROW_AW-1:0];
			fv_q     <= 1'b1;
		end
		if (cmd.fail_follow) fv_q <= 1'b0;
		if (cmd.adv_take) begin
			prior_q <= follow_q;
			pv_q    <= 1'b1;
		end
	end

	// bracketing rows, zeroed when absent
	always_ff @(posedge clk) begin
		if (cmd.ld_prior) begin
			pt_q     <= pv_q ? r_time : '0;
			p_vals_q <= pv_q ? r_vals : '0;
		end
		if (cmd.ld_follow) begin
			ft_q     <= fv_q ? r_time : '0;
			f_vals_q <= fv_q ? r_vals : '0;
		end
	end

	// weight selection by the five cases
	assign t_x  = W_W'(t_q);
	assign pt_x = W_W'(pt_q);
	assign ft_x = W_W'(ft_q);
	assign span = ft_x - pt_x;

	always_comb begin
		wa_d = '0;
		wb_d = '0;
		d_d  = DEN_W'(1);
		if (pv_q && !fv_q) begin
			wa_d = W_W'(1);
		end else if (!pv_q && fv_q) begin
			wb_d = W_W'(1);
		end else if (pv_q && fv_q) begin
			if (pt_q < t_q && ft_q < t_q) begin
				wb_d = W_W'(1);
			end else if (pt_q > t_q && ft_q > t_q) begin
				wa_d = W_W'(1);
			end else if (span == '0) begin
				wb_d = W_W'(1);
			end else if (span < 0) begin
				wa_d = t_x - ft_x;
				wb_d = pt_x - t_x;
				d_d  = DEN_W'(-span);
			end else begin
				wa_d = ft_x - t_x;
				wb_d = t_x - pt_x;
				d_d  = DEN_W'(span);
			end
		end
	end

	// blank-aware operands of value k
	assign p_val = p_vals_q[k_q*VAL_W +: VAL_W];
	assign f_val = f_vals_q[k_q*VAL_W +: VAL_W];
	assign aa    = (p_val == BLANK) ? '0 : wa_q;
	assign bb    = (f_val == BLANK) ? '0 : wb_q;
	assign m_w   = cmd.mul_b ? bb : aa;
	assign m_val = cmd.mul_b ? f_val : p_val;
	assign prod  = m_w * m_val;

	// magnitude plus half the span for round-half-away
	assign mag     = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign div_num = mag + ACC_W'(d_q >> 1);

	pati_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (d_q),
		.done   (div_done),
		.quot   (quot)
	);

	assign q_sat   = (quot > VAL_MAX) ? VAL_MAX : quot;
	assign res_val = blank_q ? BLANK : (neg_q ? VAL_W'(-q_sat) : q_sat);

	// weights, accumulate, store results
	always_ff @(posedge clk) begin
		if (cmd.wgt) begin
			wa_q <= wa_d;
			wb_q <= wb_d;
			d_q  <= d_d;
			k_q  <= '0;
		end
		if (cmd.mul_a) acc_q <= ACC_W'(prod);
		if (cmd.mul_b) begin
			acc_q   <= acc_q + ACC_W'(prod);
			blank_q <= (W_W'(aa) + W_W'(bb)) == '0;
		end
		if (cmd.div_start) neg_q <= acc_q[ACC_W-1];
		if (cmd.store) begin
			res_q[k_q*VAL_W +: VAL_W] <= res_val;
			k_q <= k_q + 1'b1;
		end
		if (cmd.res_blank) res_q <= {NVAL{BLANK}};
		if (cmd.out_load) out_data_q <= res_q;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// status to the sequencer
	assign sts.action    = act_q;
	assign sts.ant_bad   = (ant_q == '0) || (ant_q > ANT_W'(ANTENNAS));
	assign sts.started   = started_q[idx];
	assign sts.scan_end  = scan_q >= row_count_q;
	assign sts.row_match = ((r_ant == ant_q) || (r_ant == '0)) && (r_sub == cur_sub_q);
	assign sts.adv_ok    = fv_q && ((CNT_W'(follow_q) + 1'b1) < row_count_q);
	assign sts.t_after   = t_q > r_time;
	assign sts.div_done  = div_done;
	assign sts.last_val  = k_q == K_W'(NVAL - 1);
	assign sts.out_free  = !out_valid_q || out_ready;

endmodule

FILE: sv/per_antenna_time_interpolator.sv
// ----------------------------------------------------------------------------
// per_antenna_time_interpolator
// Linear interpolation of time-tagged weather rows per antenna.
// ----------------------------------------------------------------------------
// One item is taken at a time. Append, clear and the unused action code are
// executed in the state after capture, then the block returns to idle. For a
// query, the pointer search visits store rows one by one (one read of the row
// store, then a match check); decode, pointer and row fetches and weight
// selection come with it, then each of the seven values passes through the
// 24-step divider. The result sits in an output register, so a new item is
// taken while it waits. A query for antenna 0 or above ANTENNAS gives
// all-blank outputs. The stores need no clearing pass after reset.
module per_antenna_time_interpolator import pati_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// time_tag, antenna, subarray, temperature_in, dewpoint_in, pressure_in,
	// wind_direction_in, wind_speed_in, water_vapour_in, electron_content_in
	input  logic [ROW_W-1:0]  s_axis_tdata,
	// action
	input  logic [1:0]        s_axis_tuser,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// temperature_out, dewpoint_out, pressure_out, wind_direction_out,
	// wind_speed_out, water_vapour_out, electron_content_out
	output logic [VALS_W-1:0] m_axis_tdata
);

	`include "per_antenna_time_interpolator_assert.svh"

	cmd_t cmd;
	sts_t sts;

	pati_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pati_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_axis_tdata),
		.in_action (s_axis_tuser),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata)
	);

	// checks
	`PATI_ASSERT_IMPL(a_no_overwrite, cmd.out_load, sts.out_free)
	`PATI_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`PATI_ASSERT_NEXT(a_result_shown, cmd.out_load, m_axis_tvalid)

endmodule
